// ----- hw/rtl/ppbh_pkg.sv -----
// ----------------------------------------------------------------------------
// Parallel port block handshake package
// Shared types and constants for the parallel port block handshake core.
// ----------------------------------------------------------------------------
package ppbh_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_STABLE_SAMPLES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAIT_LIMIT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_LENGTH   = 2'd2;

    localparam logic [7:0]  STABLE_SAMPLES_RESET = 8'd20;
    localparam logic [23:0] WAIT_LIMIT_RESET     = 24'd1000000;
    localparam logic [12:0] BLOCK_LENGTH_RESET   = 13'd128;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_RX_START = 2'd1;
    localparam logic [1:0] CMD_TX_START = 2'd2;
    localparam logic [1:0] CMD_TX_LOAD  = 2'd3;

    // Line pair is {busy, ack} with busy already inverted from the raw bit.
    localparam logic [1:0] PAIR_GO    = 2'b01;
    localparam logic [1:0] PAIR_READY = 2'b10;
    localparam logic [1:0] PAIR_STOP  = 2'b11;

    typedef struct packed {
        logic [1:0] cmd;
        logic       busy_raw;
        logic       ack_raw;
        logic [7:0] port_data_in;
        logic [7:0] tx_byte;
        logic       timeout_enable;
    } item_t;

    typedef struct packed {
        logic        strobe_out;
        logic        init_out;
        logic        port_input_mode;
        logic [7:0]  data_out;
        logic        rx_valid;
        logic [7:0]  rx_byte;
        logic        tx_need_byte;
        logic        active;
        logic        done_res;
        logic        timeout_error;
        logic [15:0] received_count;
    } result_t;

    typedef struct packed {
        logic [7:0]  stable_samples;
        logic [23:0] wait_limit;
        logic [12:0] block_length;
    } cfg_t;

endpackage

// ----- hw/rtl/ppbh_ifs.sv -----
// ----------------------------------------------------------------------------
// Parallel port block handshake interfaces
// Request channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface ppbh_item_if;
    logic            valid;
    logic            ready;
    ppbh_pkg::item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ppbh_result_if;
    logic              valid;
    logic              ready;
    ppbh_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ppbh_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ppbh_pkg::CFG_INDEX_W-1:0] index;
    logic [ppbh_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/ppbh_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Parallel port block handshake configuration registers
// Holds stable sample count, wait limit and block length.
// ----------------------------------------------------------------------------
module ppbh_cfg_regs
(
    input  logic          clk,
    input  logic          rst_n,
    ppbh_cfg_if.sink      cfg,
    output ppbh_pkg::cfg_t regs
);

    ppbh_pkg::cfg_t regs_reg;
    ppbh_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                ppbh_pkg::CFG_STABLE_SAMPLES: regs_next.stable_samples = cfg.data[7:0];
                ppbh_pkg::CFG_WAIT_LIMIT:     regs_next.wait_limit     = cfg.data[23:0];
                ppbh_pkg::CFG_BLOCK_LENGTH:   regs_next.block_length   = cfg.data[12:0];
                default:                      regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.stable_samples <= ppbh_pkg::STABLE_SAMPLES_RESET;
            regs_reg.wait_limit     <= ppbh_pkg::WAIT_LIMIT_RESET;
            regs_reg.block_length   <= ppbh_pkg::BLOCK_LENGTH_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ----- hw/rtl/ppbh_core.sv -----
// ----------------------------------------------------------------------------
// Parallel port block handshake sequencer
// Advances the handshake by one sampling tick for every accepted request.
// ----------------------------------------------------------------------------
module ppbh_core
#(
    parameter int MAX_BLOCK = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  ppbh_pkg::item_t   item,
    input  ppbh_pkg::cfg_t    cfg,
    output ppbh_pkg::result_t result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RX_QUIET,
        PH_RX_READY,
        PH_RX_GO,
        PH_TX_NEED,
        PH_TX_READY,
        PH_TX_GO,
        PH_TX_EOT
    } phase_t;

    localparam logic [15:0] MaxLen = 16'(MAX_BLOCK);

    phase_t      phase_reg, phase_next;
    logic [7:0]  stable_run_reg, stable_run_next;
    logic [23:0] wait_ticks_reg, wait_ticks_next;
    logic [15:0] byte_counter_reg, byte_counter_next;
    logic        started_reg, started_next;
    logic        count_waits_reg, count_waits_next;
    logic [7:0]  held_tx_reg, held_tx_next;
    logic [7:0]  data_latch_reg, data_latch_next;
    logic [1:0]  last_pair_reg, last_pair_next;
    logic        strobe_reg, strobe_next;
    logic        init_reg, init_next;
    logic        input_reg, input_next;

    logic [1:0]  pair;
    logic [7:0]  run_upd;
    logic        stable_ok;
    logic        hit_go, hit_ready, hit_stop;
    logic [15:0] blk_len;
    logic [15:0] eff_len;
    logic        wait_over;
    logic [15:0] counter_inc;
    logic        expired, done, rx_valid;

    assign pair        = {~item.busy_raw, item.ack_raw};
    assign run_upd     = (pair == last_pair_reg && stable_run_reg != 8'd0)
                         ? ((stable_run_reg != 8'hFF) ? stable_run_reg + 8'd1 : stable_run_reg)
                         : 8'd1;
    assign stable_ok   = run_upd >= cfg.stable_samples;
    assign hit_go      = stable_ok && pair == ppbh_pkg::PAIR_GO;
    assign hit_ready   = stable_ok && pair == ppbh_pkg::PAIR_READY;
    assign hit_stop    = stable_ok && pair == ppbh_pkg::PAIR_STOP;
    assign blk_len     = {3'b000, cfg.block_length};
    assign eff_len     = (blk_len > MaxLen) ? MaxLen : blk_len;
    assign wait_over   = wait_ticks_reg >= cfg.wait_limit;
    assign counter_inc = (byte_counter_reg != 16'hFFFF) ? byte_counter_reg + 16'd1
                                                        : byte_counter_reg;

    always_comb
    begin
        phase_next        = phase_reg;
        stable_run_next   = run_upd;
        wait_ticks_next   = wait_ticks_reg;
        byte_counter_next = byte_counter_reg;
        started_next      = started_reg;
        count_waits_next  = count_waits_reg;
        held_tx_next      = held_tx_reg;
        data_latch_next   = data_latch_reg;
        last_pair_next    = pair;
        strobe_next       = strobe_reg;
        init_next         = init_reg;
        input_next        = input_reg;
        expired           = 1'b0;
        done              = 1'b0;
        rx_valid          = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (item.cmd == ppbh_pkg::CMD_RX_START)
                begin
                    input_next        = 1'b1;
                    strobe_next       = 1'b0;
                    init_next         = 1'b0;
                    byte_counter_next = 16'd0;
                    started_next      = 1'b0;
                    count_waits_next  = item.timeout_enable;
                    phase_next        = PH_RX_QUIET;
                    stable_run_next   = 8'd0;
                    wait_ticks_next   = 24'd0;
                end
                else if (item.cmd == ppbh_pkg::CMD_TX_START)
                begin
                    input_next        = 1'b0;
                    strobe_next       = 1'b0;
                    init_next         = 1'b0;
                    byte_counter_next = 16'd0;
                    if (eff_len == 16'd0)
                    begin
                        init_next  = 1'b1;
                        phase_next = PH_TX_EOT;
                    end
                    else
                    begin
                        phase_next = PH_TX_NEED;
                    end
                end
            end
            PH_RX_QUIET:
            begin
                if (pair != ppbh_pkg::PAIR_STOP)
                begin
                    strobe_next     = 1'b1;
                    phase_next      = PH_RX_READY;
                    stable_run_next = 8'd0;
                    wait_ticks_next = 24'd0;
                end
                else if (wait_over)
                begin
                    expired = 1'b1;
                end
                else
                begin
                    wait_ticks_next = wait_ticks_reg + 24'd1;
                end
            end
            PH_RX_READY:
            begin
                if (hit_ready)
                begin
                    started_next      = 1'b1;
                    rx_valid          = byte_counter_reg < eff_len;
                    byte_counter_next = counter_inc;
                    strobe_next       = 1'b0;
                    init_next         = 1'b1;
                    phase_next        = PH_RX_GO;
                    stable_run_next   = 8'd0;
                    wait_ticks_next   = 24'd0;
                end
                else if (hit_stop && started_reg)
                begin
                    done = 1'b1;
                end
                else if (count_waits_reg)
                begin
                    if (wait_over)
                    begin
                        expired = 1'b1;
                    end
                    else
                    begin
                        wait_ticks_next = wait_ticks_reg + 24'd1;
                    end
                end
            end
            PH_RX_GO:
            begin
                if (hit_go)
                begin
                    init_next       = 1'b0;
                    strobe_next     = 1'b1;
                    phase_next      = PH_RX_READY;
                    stable_run_next = 8'd0;
                    wait_ticks_next = 24'd0;
                end
                else if (wait_over)
                begin
                    expired = 1'b1;
                end
                else
                begin
                    wait_ticks_next = wait_ticks_reg + 24'd1;
                end
            end
            PH_TX_NEED:
            begin
                if (item.cmd == ppbh_pkg::CMD_TX_LOAD)
                begin
                    held_tx_next    = item.tx_byte;
                    strobe_next     = 1'b1;
                    phase_next      = PH_TX_READY;
                    stable_run_next = 8'd0;
                    wait_ticks_next = 24'd0;
                end
            end
            PH_TX_READY:
            begin
                if (hit_ready)
                begin
                    data_latch_next = held_tx_reg;
                    strobe_next     = 1'b0;
                    phase_next      = PH_TX_GO;
                    stable_run_next = 8'd0;
                    wait_ticks_next = 24'd0;
                end
                else if (wait_over)
                begin
                    expired = 1'b1;
                end
                else
                begin
                    wait_ticks_next = wait_ticks_reg + 24'd1;
                end
            end
            PH_TX_GO:
            begin
                if (hit_go)
                begin
                    byte_counter_next = counter_inc;
                    if (counter_inc >= eff_len)
                    begin
                        init_next  = 1'b1;
                        phase_next = PH_TX_EOT;
                    end
                    else
                    begin
                        phase_next = PH_TX_NEED;
                    end
                end
                else if (wait_over)
                begin
                    expired = 1'b1;
                end
                else
                begin
                    wait_ticks_next = wait_ticks_reg + 24'd1;
                end
            end
            PH_TX_EOT:
            begin
                done = 1'b1;
            end
        endcase

        if (expired)
        begin
            done = 1'b1;
        end
        if (done)
        begin
            strobe_next     = 1'b0;
            init_next       = 1'b0;
            phase_next      = PH_IDLE;
            wait_ticks_next = 24'd0;
            stable_run_next = 8'd0;
        end

        result.strobe_out      = strobe_next;
        result.init_out        = init_next;
        result.port_input_mode = input_next;
        result.data_out        = input_next ? 8'd0 : data_latch_next;
        result.rx_valid        = rx_valid;
        result.rx_byte         = rx_valid ? item.port_data_in : 8'd0;
        result.tx_need_byte    = phase_next == PH_TX_NEED;
        result.active          = phase_next != PH_IDLE;
        result.done_res        = done;
        result.timeout_error   = expired;
        result.received_count  = byte_counter_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            stable_run_reg   <= 8'd0;
            wait_ticks_reg   <= 24'd0;
            byte_counter_reg <= 16'd0;
            started_reg      <= 1'b0;
            count_waits_reg  <= 1'b0;
            held_tx_reg      <= 8'd0;
            data_latch_reg   <= 8'd0;
            last_pair_reg    <= 2'b00;
            strobe_reg       <= 1'b0;
            init_reg         <= 1'b0;
            input_reg        <= 1'b1;
        end
        else if (fire)
        begin
            phase_reg        <= phase_next;
            stable_run_reg   <= stable_run_next;
            wait_ticks_reg   <= wait_ticks_next;
            byte_counter_reg <= byte_counter_next;
            started_reg      <= started_next;
            count_waits_reg  <= count_waits_next;
            held_tx_reg      <= held_tx_next;
            data_latch_reg   <= data_latch_next;
            last_pair_reg    <= last_pair_next;
            strobe_reg       <= strobe_next;
            init_reg         <= init_next;
            input_reg        <= input_next;
        end
    end

endmodule

// ----- hw/rtl/ppbh_out_buf.sv -----
// ----------------------------------------------------------------------------
// Parallel port block handshake result buffer
// Output register and skid stage; one stalled result does not block input.
// ----------------------------------------------------------------------------
module ppbh_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ppbh_pkg::result_t push_data,
    output logic              push_ready,
    ppbh_result_if.source     result
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    ppbh_pkg::result_t out_data_reg, out_data_next;
    ppbh_pkg::result_t skid_data_reg, skid_data_next;
    logic              slot_free;

    assign push_ready     = !skid_valid_reg;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;
    assign slot_free      = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (slot_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_data_next  = push_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_data_next  = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ----- hw/rtl/parallel_port_block_handshake_core.sv -----
// ----------------------------------------------------------------------------
// Parallel port block handshake core
// Host side of a byte-wide parallel-port block transfer, one tick per request.
// ----------------------------------------------------------------------------
// Results are registered at the output, or in the skid stage while it stalls.
// Throughput: one request per cycle while the skid stage is empty.
// A two-entry result buffer keeps input flowing while one result is stalled.
// Reset: asynchronous, active low; sequencer goes idle with lines in input mode,
// registers take their default values, and the result buffer empties.
module parallel_port_block_handshake_core
#(
    parameter int MAX_BLOCK = 4096
)
(
    input  logic          clk,
    input  logic          rst_n,
    ppbh_item_if.sink     item,
    ppbh_result_if.source result,
    ppbh_cfg_if.sink      cfg
);

    ppbh_pkg::cfg_t    regs;
    ppbh_pkg::result_t step_result;
    logic              buf_ready;
    logic              fire;

    assign item.ready = buf_ready;
    assign fire       = item.valid && buf_ready;

    ppbh_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    ppbh_core
    #(
        .MAX_BLOCK (MAX_BLOCK)
    )
    u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item.payload),
        .cfg    (regs),
        .result (step_result)
    );

    ppbh_out_buf u_out_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fire),
        .push_data  (step_result),
        .push_ready (buf_ready),
        .result     (result)
    );

endmodule

// ----- hw/rtl/ppbh_checker.sv -----
// ----------------------------------------------------------------------------
// Parallel port block handshake checker
// Port-level assertions on result requests, bound to the top level.
// ----------------------------------------------------------------------------
module ppbh_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input ppbh_pkg::result_t out_data
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result request changed or dropped.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.timeout_error |-> out_data.done_res)
    else $error("Timeout reported without the transfer ending.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |->
            !out_data.strobe_out && !out_data.init_out && !out_data.active)
    else $error("Finished transfer left control lines raised or stayed active.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.rx_valid |-> out_data.port_input_mode && out_data.active)
    else $error("Received byte shown while data lines are driven.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.tx_need_byte |-> out_data.active && !out_data.port_input_mode)
    else $error("Transmit byte requested outside an output transfer.");

endmodule

bind parallel_port_block_handshake_core ppbh_checker u_ppbh_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.payload)
);

// ----- verif/tb_parallel_port_block_handshake_core.sv -----
// ----------------------------------------------------------------------------
// Parallel port block handshake core testbench
// Drives port ticks through the request channel, acting as a reactive link
// partner built on an in-bench model of the host sequencer. A short table of
// hand-picked ticks comes first, followed by randomized transfers under a
// series of register settings and idle patterns on both channels. Results
// are checked field by field against model predictions or typed row results.
// ----------------------------------------------------------------------------
module tb_parallel_port_block_handshake_core;
    import ppbh_pkg::*;

    localparam int MAX_BLOCK   = 4096;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 100;

    localparam logic [1:0] PAIR_NONE = 2'b00;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_RX_QUIET,
        SEQ_RX_READY,
        SEQ_RX_GO,
        SEQ_TX_NEED,
        SEQ_TX_READY,
        SEQ_TX_GO,
        SEQ_TX_EOT
    } link_seq_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] pair;
        logic [7:0] pin;
        logic [7:0] txb;
        logic       ten;
        logic       typed;
        result_t    want;
    } tick_row_t;

    typedef struct {
        int unsigned stable;
        int unsigned limit;
        int unsigned len;
        int          items;
        int          send_pct;
        int          stall_pct;
    } link_setup_t;

    localparam result_t RES_IDLE_IN =
        '{1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000};
    localparam result_t RES_RX_OPEN =
        '{1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000};
    localparam result_t RES_RX_TIMEOUT =
        '{1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 16'h0000};
    localparam result_t RES_TX_TIMEOUT =
        '{1'b0, 1'b0, 1'b0, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 16'h0000};

    tick_row_t tick_rows [22] = '{
        '{CMD_TICK,     PAIR_NONE,  8'h00, 8'h00, 1'b0, 1'b1, RES_IDLE_IN},
        '{CMD_TX_LOAD,  PAIR_STOP,  8'hFF, 8'hFF, 1'b1, 1'b1, RES_IDLE_IN},
        '{CMD_RX_START, PAIR_STOP,  8'h00, 8'h00, 1'b1, 1'b1, RES_RX_OPEN},
        '{CMD_RX_START, PAIR_STOP,  8'h00, 8'h00, 1'b0, 1'b1, RES_RX_TIMEOUT},
        '{CMD_RX_START, PAIR_NONE,  8'h5A, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_TICK,     PAIR_READY, 8'hA5, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_TICK,     PAIR_STOP,  8'h00, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_TICK,     PAIR_READY, 8'hFF, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_TICK,     PAIR_GO,    8'h00, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_TICK,     PAIR_READY, 8'h00, 8'hFF, 1'b0, 1'b0, '0},
        '{CMD_TICK,     PAIR_GO,    8'h00, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_TICK,     PAIR_STOP,  8'h00, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_TX_START, PAIR_NONE,  8'h00, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_RX_START, PAIR_NONE,  8'h00, 8'h00, 1'b1, 1'b0, '0},
        '{CMD_TX_LOAD,  PAIR_NONE,  8'h00, 8'hFF, 1'b0, 1'b0, '0},
        '{CMD_TICK,     PAIR_READY, 8'h00, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_TICK,     PAIR_GO,    8'h00, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_TICK,     PAIR_NONE,  8'h00, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_TX_START, PAIR_NONE,  8'h00, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_TX_LOAD,  PAIR_NONE,  8'h00, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_TICK,     PAIR_NONE,  8'h00, 8'h00, 1'b1, 1'b1, RES_TX_TIMEOUT},
        '{CMD_TICK,     PAIR_GO,    8'hFF, 8'hFF, 1'b1, 1'b0, '0}
    };

    link_setup_t link_setups [8] = '{
        '{1,   24'hFFFFFF, 3,    90,  0,  0},
        '{3,   30,         2,    90,  61, 0},
        '{0,   5,          0,    70,  0,  61},
        '{2,   1,          8191, 80,  9,  9},
        '{255, 100,        1,    110, 0,  0},
        '{4,   1000,       4096, 80,  61, 0},
        '{1,   0,          5,    60,  0,  61},
        '{20,  1000000,    128,  70,  9,  9}
    };

    logic clk;
    logic rst_n;

    ppbh_item_if   item_bus();
    ppbh_result_if result_bus();
    ppbh_cfg_if    cfg_bus();

    parallel_port_block_handshake_core #(
        .MAX_BLOCK(MAX_BLOCK)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_bus),
        .result(result_bus),
        .cfg(cfg_bus)
    );

    logic [7:0]  m_stable = STABLE_SAMPLES_RESET;
    logic [23:0] m_limit  = WAIT_LIMIT_RESET;
    logic [12:0] m_len    = BLOCK_LENGTH_RESET;

    link_seq_t   m_seq        = SEQ_IDLE;
    logic [7:0]  m_run        = '0;
    logic [23:0] m_wait       = '0;
    logic [15:0] m_count      = '0;
    logic        m_started    = 1'b0;
    logic        m_data_waits = 1'b0;
    logic [7:0]  m_held       = '0;
    logic [7:0]  m_latch      = '0;
    logic [1:0]  m_last_pair  = '0;
    logic        m_strobe     = 1'b0;
    logic        m_init       = 1'b0;
    logic        m_input      = 1'b1;

    result_t port_status_q [$];
    logic    typed_pending = 1'b0;
    result_t typed_want    = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rx_goal        = 1;
    int mismatch_count = 0;
    int cycle_count    = 0;

    always #4 clk = ~clk;

    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        if (mismatch_count < PRINT_LIMIT)
            $display("ERROR at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic compare_status(input result_t got, input result_t want);
        if (got.strobe_out !== want.strobe_out)
            flag_mismatch("strobe_out", 64'(got.strobe_out), 64'(want.strobe_out));
        if (got.init_out !== want.init_out)
            flag_mismatch("init_out", 64'(got.init_out), 64'(want.init_out));
        if (got.port_input_mode !== want.port_input_mode)
            flag_mismatch("port_input_mode", 64'(got.port_input_mode),
                          64'(want.port_input_mode));
        if (got.data_out !== want.data_out)
            flag_mismatch("data_out", 64'(got.data_out), 64'(want.data_out));
        if (got.rx_valid !== want.rx_valid)
            flag_mismatch("rx_valid", 64'(got.rx_valid), 64'(want.rx_valid));
        if (got.rx_byte !== want.rx_byte)
            flag_mismatch("rx_byte", 64'(got.rx_byte), 64'(want.rx_byte));
        if (got.tx_need_byte !== want.tx_need_byte)
            flag_mismatch("tx_need_byte", 64'(got.tx_need_byte), 64'(want.tx_need_byte));
        if (got.active !== want.active)
            flag_mismatch("active", 64'(got.active), 64'(want.active));
        if (got.done_res !== want.done_res)
            flag_mismatch("done_res", 64'(got.done_res), 64'(want.done_res));
        if (got.timeout_error !== want.timeout_error)
            flag_mismatch("timeout_error", 64'(got.timeout_error),
                          64'(want.timeout_error));
        if (got.received_count !== want.received_count)
            flag_mismatch("received_count", 64'(got.received_count),
                          64'(want.received_count));
    endtask

    function automatic void open_wait(input link_seq_t next_seq);
        m_seq  = next_seq;
        m_run  = '0;
        m_wait = '0;
    endfunction

    function automatic logic wait_over();
        if (m_wait >= m_limit)
            return 1'b1;
        m_wait = m_wait + 24'd1;
        return 1'b0;
    endfunction

    function automatic void count_byte();
        if (m_count != 16'hFFFF)
            m_count = m_count + 16'd1;
    endfunction

    function automatic result_t predict_port_tick(input item_t it);
        result_t     r;
        logic [1:0]  pair;
        logic [15:0] eff;
        logic        met_ready;
        logic        met_go;
        logic        met_stop;
        logic        rx_take;
        logic        done;
        logic        expired;
        pair    = {~it.busy_raw, it.ack_raw};
        eff     = (m_len > 13'(MAX_BLOCK)) ? 16'(MAX_BLOCK) : 16'(m_len);
        rx_take = 1'b0;
        done    = 1'b0;
        expired = 1'b0;
        if (pair == m_last_pair && m_run != 8'd0)
        begin
            if (m_run != 8'hFF)
                m_run = m_run + 8'd1;
        end
        else
        begin
            m_run = 8'd1;
        end
        m_last_pair = pair;
        met_ready = (pair == PAIR_READY) && (m_run >= m_stable);
        met_go    = (pair == PAIR_GO) && (m_run >= m_stable);
        met_stop  = (pair == PAIR_STOP) && (m_run >= m_stable);
        case (m_seq)
            SEQ_IDLE:
            begin
                if (it.cmd == CMD_RX_START)
                begin
                    m_input      = 1'b1;
                    m_strobe     = 1'b0;
                    m_init       = 1'b0;
                    m_count      = '0;
                    m_started    = 1'b0;
                    m_data_waits = it.timeout_enable;
                    open_wait(SEQ_RX_QUIET);
                end
                else if (it.cmd == CMD_TX_START)
                begin
                    m_input  = 1'b0;
                    m_strobe = 1'b0;
                    m_init   = 1'b0;
                    m_count  = '0;
                    if (eff == 16'd0)
                    begin
                        m_init = 1'b1;
                        m_seq  = SEQ_TX_EOT;
                    end
                    else
                    begin
                        m_seq = SEQ_TX_NEED;
                    end
                end
            end
            SEQ_RX_QUIET:
            begin
                if (pair != PAIR_STOP)
                begin
                    m_strobe = 1'b1;
                    open_wait(SEQ_RX_READY);
                end
                else
                begin
                    expired = wait_over();
                end
            end
            SEQ_RX_READY:
            begin
                if (met_ready)
                begin
                    m_started = 1'b1;
                    rx_take   = (m_count < eff);
                    count_byte();
                    m_strobe = 1'b0;
                    m_init   = 1'b1;
                    open_wait(SEQ_RX_GO);
                end
                else if (met_stop && m_started)
                begin
                    done = 1'b1;
                end
                else if (m_data_waits)
                begin
                    expired = wait_over();
                end
            end
            SEQ_RX_GO:
            begin
                if (met_go)
                begin
                    m_init   = 1'b0;
                    m_strobe = 1'b1;
                    open_wait(SEQ_RX_READY);
                end
                else
                begin
                    expired = wait_over();
                end
            end
            SEQ_TX_NEED:
            begin
                if (it.cmd == CMD_TX_LOAD)
                begin
                    m_held   = it.tx_byte;
                    m_strobe = 1'b1;
                    open_wait(SEQ_TX_READY);
                end
            end
            SEQ_TX_READY:
            begin
                if (met_ready)
                begin
                    m_latch  = m_held;
                    m_strobe = 1'b0;
                    open_wait(SEQ_TX_GO);
                end
                else
                begin
                    expired = wait_over();
                end
            end
            SEQ_TX_GO:
            begin
                if (met_go)
                begin
                    count_byte();
                    if (m_count >= eff)
                    begin
                        m_init = 1'b1;
                        m_seq  = SEQ_TX_EOT;
                    end
                    else
                    begin
                        m_seq = SEQ_TX_NEED;
                    end
                end
                else
                begin
                    expired = wait_over();
                end
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
        if (expired)
            done = 1'b1;
        if (done)
        begin
            m_strobe = 1'b0;
            m_init   = 1'b0;
            m_seq    = SEQ_IDLE;
            m_wait   = '0;
            m_run    = '0;
        end
        r.strobe_out      = m_strobe;
        r.init_out        = m_init;
        r.port_input_mode = m_input;
        r.data_out        = m_input ? 8'h00 : m_latch;
        r.rx_valid        = rx_take;
        r.rx_byte         = rx_take ? it.port_data_in : 8'h00;
        r.tx_need_byte    = (m_seq == SEQ_TX_NEED);
        r.active          = (m_seq != SEQ_IDLE);
        r.done_res        = done;
        r.timeout_error   = expired;
        r.received_count  = m_count;
        return r;
    endfunction

    function automatic item_t with_lines(input item_t it, input logic [1:0] pair);
        item_t r;
        r          = it;
        r.busy_raw = ~pair[1];
        r.ack_raw  = pair[0];
        return r;
    endfunction

    function automatic item_t partner_tick();
        item_t      it;
        logic [1:0] pair;
        it.cmd            = CMD_TICK;
        it.busy_raw       = 1'b0;
        it.ack_raw        = 1'b0;
        it.port_data_in   = 8'($urandom_range(255));
        it.tx_byte        = 8'($urandom_range(255));
        it.timeout_enable = 1'($urandom_range(1));
        pair              = 2'($urandom_range(3));
        if ($urandom_range(99) < 5)
            it.cmd = 2'($urandom_range(3));
        case (m_seq) inside
            SEQ_IDLE:
            begin
                case ($urandom_range(9)) inside
                    0:       it.cmd = CMD_TICK;
                    1:       it.cmd = CMD_TX_LOAD;
                    [2:5]:   it.cmd = CMD_RX_START;
                    default: it.cmd = CMD_TX_START;
                endcase
                rx_goal = $urandom_range(1, 6);
            end
            SEQ_RX_READY:
                pair = (!m_started || m_count < rx_goal) ? PAIR_READY : PAIR_STOP;
            SEQ_RX_GO, SEQ_TX_GO:
                pair = PAIR_GO;
            SEQ_TX_NEED:
                if ($urandom_range(4) != 0)
                    it.cmd = CMD_TX_LOAD;
            SEQ_TX_READY:
                pair = PAIR_READY;
            default:
                ;
        endcase
        if ($urandom_range(99) < 7)
            pair = 2'($urandom_range(3));
        return with_lines(it, pair);
    endfunction

    task automatic send_item(input item_t it, input logic typed, input result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(negedge clk);
        end
        item_bus.valid   <= 1'b1;
        item_bus.payload <= it;
        typed_pending = typed;
        typed_want    = want;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [7:0] stable, input logic [23:0] limit,
                                 input logic [12:0] len);
        logic [CFG_INDEX_W-1:0] idx [3];
        logic [CFG_DATA_W-1:0]  val [3];
        idx = '{CFG_STABLE_SAMPLES, CFG_WAIT_LIMIT, CFG_BLOCK_LENGTH};
        val = '{24'(stable), limit, 24'(len)};
        for (int k = 0; k < 3; k++)
        begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx[k];
            cfg_bus.data  <= val[k];
            @(posedge clk);
            while (!cfg_bus.ready)
                @(posedge clk);
            @(negedge clk);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (port_status_q.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
        result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (result_bus.valid && result_bus.ready)
        begin
            if (port_status_q.size() == 0)
            begin
                flag_mismatch("result with no request pending", 64'(result_bus.payload),
                              64'd0);
            end
            else
            begin
                want = port_status_q.pop_front();
                compare_status(result_bus.payload, want);
            end
        end
        if (item_bus.valid && item_bus.ready)
        begin
            want = predict_port_tick(item_bus.payload);
            port_status_q.push_back(typed_pending ? typed_want : want);
        end
        if (cfg_bus.valid && cfg_bus.ready)
        begin
            case (cfg_bus.index)
                CFG_STABLE_SAMPLES: m_stable = cfg_bus.data[7:0];
                CFG_WAIT_LIMIT:     m_limit  = cfg_bus.data;
                CFG_BLOCK_LENGTH:   m_len    = cfg_bus.data[12:0];
                default:            ;
            endcase
        end
    end

    initial
    begin
        tick_row_t row;
        item_t     it;
        clk              = 1'b0;
        rst_n            = 1'b0;
        item_bus.valid   = 1'b0;
        item_bus.payload = '0;
        result_bus.ready = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = '0;
        cfg_bus.data     = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        apply_setting(8'd0, 24'd0, 13'd1);
        foreach (tick_rows[i])
        begin
            row = tick_rows[i];
            it  = '{cmd: row.cmd, busy_raw: 1'b0, ack_raw: 1'b0, port_data_in: row.pin,
                    tx_byte: row.txb, timeout_enable: row.ten};
            send_item(with_lines(it, row.pair), row.typed, row.want);
        end
        item_bus.valid <= 1'b0;
        drain_results();

        foreach (link_setups[p])
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            apply_setting(8'(link_setups[p].stable), 24'(link_setups[p].limit),
                          13'(link_setups[p].len));
            send_idle_pct  = link_setups[p].send_pct;
            recv_stall_pct = link_setups[p].stall_pct;
            for (int n = 0; n < link_setups[p].items; n++)
                send_item(partner_tick(), 1'b0, '0);
            item_bus.valid <= 1'b0;
            drain_results();
        end

        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/ppbh_pkg.sv
hw/rtl/ppbh_ifs.sv
hw/rtl/ppbh_cfg_regs.sv
hw/rtl/ppbh_core.sv
hw/rtl/ppbh_out_buf.sv
hw/rtl/parallel_port_block_handshake_core.sv
hw/rtl/ppbh_checker.sv
verif/tb_parallel_port_block_handshake_core.sv
